/* rtl/tea_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_pkg
// Shared widths, codes and constants of the TEA block cipher pipeline.
// ----------------------------------------------------------------------------
package tea_pkg;

   localparam int WORD_WIDTH      = 32;
   localparam int REQ_DATA_WIDTH  = 2 * WORD_WIDTH;
   localparam int RSP_DATA_WIDTH  = 2 * WORD_WIDTH;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int KEY_WORDS       = 4;

   localparam logic [WORD_WIDTH-1:0] TEA_DELTA = 32'h9e37_79b9;

   typedef enum logic {
      OP_ENCRYPT = 1'b0,
      OP_DECRYPT = 1'b1
   } opcode_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_KEY_WORD_0 = 2'd0,
      CSR_KEY_WORD_1 = 2'd1,
      CSR_KEY_WORD_2 = 2'd2,
      CSR_KEY_WORD_3 = 2'd3
   } csr_index_type;

endpackage

/* rtl/tea_block_cipher_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_block_cipher_top
// TEA cipher, 64-bit block, 128-bit key, one half-round per pipeline stage.
//
// Usage:
//   req_* carries one block per beat: tdata = {block_high, block_low},
//   tuser = opcode (0 encrypt, 1 decrypt). rsp_* returns the transformed
//   block as tdata = {out_high, out_low}, one beat per request, in order.
//   The key is written through csr_* (index 0..3 = key words 0..3) while
//   no block is in flight.
//   The first half-round stage captures the request beat itself; the
//   block then passes through the other 2*ROUND_COUNT-1 half-round
//   stages and the output register. Throughput: one block per cycle
//   while the response side does not stall, set by the unrolled
//   half-round stages.
//   A response stalled by rsp_tready low is held in the output register;
//   one more block drains into a skid register, after which req_tready
//   drops and the whole pipeline holds. Nothing is lost or repeated.
//   Reset (synchronous, active high) empties the pipeline and clears the
//   key to zero.
// ----------------------------------------------------------------------------
module tea_block_cipher_top #(
   parameter int ROUND_COUNT = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // fields: block_low [31:0], block_high [63:32]
   input  logic [tea_pkg::REQ_DATA_WIDTH-1:0]    req_tdata,
   // fields: opcode [0]
   input  logic                                  req_tuser,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // fields: out_low [31:0], out_high [63:32]
   output logic [tea_pkg::RSP_DATA_WIDTH-1:0]    rsp_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic                                  csr_wr_en,
   input  logic [tea_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [tea_pkg::WORD_WIDTH-1:0]        csr_wdata
);
   import tea_pkg::*;

   localparam int StageCount = 2 * ROUND_COUNT;
   localparam int LastStage  = StageCount - 1;

   function automatic logic [WORD_WIDTH-1:0] tea_mix(
      input logic [WORD_WIDTH-1:0] w,
      input logic [WORD_WIDTH-1:0] s,
      input logic [WORD_WIDTH-1:0] ka,
      input logic [WORD_WIDTH-1:0] kb
   );
      return ((w << 4) + ka) ^ (w + s) ^ ((w >> 5) + kb);
   endfunction

   logic [WORD_WIDTH-1:0] key_ff [KEY_WORDS];

   logic [WORD_WIDTH-1:0] stage_v0_ff    [StageCount];
   logic [WORD_WIDTH-1:0] stage_v1_ff    [StageCount];
   opcode_type            stage_op_ff    [StageCount];
   logic                  stage_valid_ff [StageCount];
   logic [WORD_WIDTH-1:0] stage_v0_in    [StageCount];
   logic [WORD_WIDTH-1:0] stage_v1_in    [StageCount];
   opcode_type            stage_op_in    [StageCount];
   logic                  stage_valid_in [StageCount];

   logic [RSP_DATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_WIDTH-1:0] skid_data_ff, skid_data_in;
   logic                      skid_valid_ff, skid_valid_in;
   logic                      pipe_en;
   logic                      pipe_exit;

   assign pipe_en    = !skid_valid_ff;
   assign req_tready = pipe_en;
   assign pipe_exit  = pipe_en && stage_valid_ff[LastStage];

   // key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < KEY_WORDS; k++) begin
            key_ff[k] <= '0;
         end
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_KEY_WORD_0: key_ff[0] <= csr_wdata;
            CSR_KEY_WORD_1: key_ff[1] <= csr_wdata;
            CSR_KEY_WORD_2: key_ff[2] <= csr_wdata;
            CSR_KEY_WORD_3: key_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // half-round stages
   for (genvar g = 0; g < StageCount; g++) begin : g_stage
      localparam int Round = g / 2;
      localparam bit FirstHalf = ((g % 2) == 0);
      localparam logic [WORD_WIDTH-1:0] EncSum =
         WORD_WIDTH'(64'(TEA_DELTA) * 64'(Round + 1));
      localparam logic [WORD_WIDTH-1:0] DecSum =
         WORD_WIDTH'(64'(TEA_DELTA) * 64'(ROUND_COUNT - Round));

      logic [WORD_WIDTH-1:0] src_v0, src_v1;
      opcode_type            src_op;
      logic                  src_valid;
      logic                  decrypt;
      logic                  upd_low;
      logic [WORD_WIDTH-1:0] mix_word, mix_val;
      logic [WORD_WIDTH-1:0] key_a, key_b;
      logic [WORD_WIDTH-1:0] sum_sel;
      logic [WORD_WIDTH-1:0] target, updated;

      if (g == 0) begin : g_head
         assign src_v0    = req_tdata[WORD_WIDTH-1:0];
         assign src_v1    = req_tdata[2*WORD_WIDTH-1:WORD_WIDTH];
         assign src_op    = opcode_type'(req_tuser);
         assign src_valid = req_tvalid;
      end else begin : g_body
         assign src_v0    = stage_v0_ff[g-1];
         assign src_v1    = stage_v1_ff[g-1];
         assign src_op    = stage_op_ff[g-1];
         assign src_valid = stage_valid_ff[g-1];
      end

      // encrypt: low word first; decrypt: high word first
      assign decrypt  = (src_op == OP_DECRYPT);
      assign upd_low  = (!decrypt) == FirstHalf;
      assign sum_sel  = decrypt ? DecSum : EncSum;
      assign mix_word = upd_low ? src_v1 : src_v0;
      assign key_a    = upd_low ? key_ff[0] : key_ff[2];
      assign key_b    = upd_low ? key_ff[1] : key_ff[3];
      assign mix_val  = tea_mix(mix_word, sum_sel, key_a, key_b);
      assign target   = upd_low ? src_v0 : src_v1;
      assign updated  = decrypt ? (target - mix_val) : (target + mix_val);

      assign stage_v0_in[g]    = upd_low ? updated : src_v0;
      assign stage_v1_in[g]    = upd_low ? src_v1 : updated;
      assign stage_op_in[g]    = src_op;
      assign stage_valid_in[g] = src_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < StageCount; i++) begin
            stage_valid_ff[i] <= 1'b0;
         end
      end else if (pipe_en) begin
         for (int i = 0; i < StageCount; i++) begin
            stage_valid_ff[i] <= stage_valid_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int i = 0; i < StageCount; i++) begin
            stage_v0_ff[i] <= stage_v0_in[i];
            stage_v1_ff[i] <= stage_v1_in[i];
            stage_op_ff[i] <= stage_op_in[i];
         end
      end
   end

   // output register and skid
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (rsp_tready) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (pipe_exit) begin
         if (!rsp_valid_ff || rsp_tready) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = {stage_v1_ff[LastStage], stage_v0_ff[LastStage]};
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = {stage_v1_ff[LastStage], stage_v0_ff[LastStage]};
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tvalid = rsp_valid_ff;

   // checks
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds a beat while output register is empty");

   a_exit_lands: assert property (@(posedge clock) disable iff (reset)
      pipe_exit |=> rsp_valid_ff)
      else $error("beat leaving pipeline was dropped");

   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_tready) |=>
         (skid_valid_ff && $stable(stage_valid_ff[LastStage])
          && $stable(skid_data_ff)))
      else $error("pipeline moved while skid was full");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !skid_valid_ff))
      else $error("output not empty after reset");

endmodule

/* test/tea_block_cipher_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_block_cipher_top_tb
// Self-checking bench for the TEA block cipher pipeline.
//
// Blocks are pushed in bursts under several key settings, including all-zero
// and all-one keys. Each accepted block is enciphered or deciphered in the
// bench's own TEA model and queued. Each response is then checked against
// the oldest queued block, word by word. Random traffic mixes single blocks
// with encrypt/decrypt round trips. The response side stalls on changing
// patterns, and once holds off long enough to back up the whole pipeline.
// ----------------------------------------------------------------------------
module tea_block_cipher_top_tb;
   import tea_pkg::*;

   localparam int ROUNDS      = 32;
   localparam int LATENCY     = 2 * ROUNDS + 1;
   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD   = 400;

   class tea_scoreboard;
      logic [WORD_WIDTH-1:0]     key_word [KEY_WORDS];
      logic [RSP_DATA_WIDTH-1:0] expected_blocks [$];
      int                        mismatches;
      int                        beats_checked;

      function new();
         foreach (key_word[i]) key_word[i] = '0;
         mismatches    = 0;
         beats_checked = 0;
      endfunction

      function void set_key(csr_index_type idx, logic [WORD_WIDTH-1:0] value);
         key_word[idx] = value;
      endfunction

      function logic [WORD_WIDTH-1:0] feistel_mix(logic [WORD_WIDTH-1:0] w,
                                                  logic [WORD_WIDTH-1:0] sum,
                                                  logic [WORD_WIDTH-1:0] ka,
                                                  logic [WORD_WIDTH-1:0] kb);
         return ((w << 4) + ka) ^ (w + sum) ^ ((w >> 5) + kb);
      endfunction

      function logic [RSP_DATA_WIDTH-1:0] cipher(opcode_type op,
                                                 logic [WORD_WIDTH-1:0] lo,
                                                 logic [WORD_WIDTH-1:0] hi);
         logic [WORD_WIDTH-1:0] v0;
         logic [WORD_WIDTH-1:0] v1;
         logic [WORD_WIDTH-1:0] sum;
         v0 = lo;
         v1 = hi;
         if (op == OP_ENCRYPT) begin
            sum = '0;
            for (int r = 0; r < ROUNDS; r++) begin
               sum = sum + TEA_DELTA;
               v0  = v0 + feistel_mix(v1, sum, key_word[CSR_KEY_WORD_0],
                                      key_word[CSR_KEY_WORD_1]);
               v1  = v1 + feistel_mix(v0, sum, key_word[CSR_KEY_WORD_2],
                                      key_word[CSR_KEY_WORD_3]);
            end
         end else begin
            sum = TEA_DELTA * 32'(ROUNDS);
            for (int r = 0; r < ROUNDS; r++) begin
               v1  = v1 - feistel_mix(v0, sum, key_word[CSR_KEY_WORD_2],
                                      key_word[CSR_KEY_WORD_3]);
               v0  = v0 - feistel_mix(v1, sum, key_word[CSR_KEY_WORD_0],
                                      key_word[CSR_KEY_WORD_1]);
               sum = sum - TEA_DELTA;
            end
         end
         return {v1, v0};
      endfunction

      function void note_block(opcode_type op, logic [WORD_WIDTH-1:0] lo,
                               logic [WORD_WIDTH-1:0] hi);
         expected_blocks.push_back(cipher(op, lo, hi));
      endfunction

      function void check_result(logic [RSP_DATA_WIDTH-1:0] got);
         logic [RSP_DATA_WIDTH-1:0] want;
         beats_checked++;
         if (expected_blocks.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("beat %0d: unexpected response %h", beats_checked, got);
            return;
         end
         want = expected_blocks.pop_front();
         if (got[WORD_WIDTH-1:0] !== want[WORD_WIDTH-1:0] ||
             got[RSP_DATA_WIDTH-1:WORD_WIDTH] !== want[RSP_DATA_WIDTH-1:WORD_WIDTH]) begin
            mismatches++;
            if (mismatches <= 10)
               $display("beat %0d: out_low exp %h got %h, out_high exp %h got %h",
                        beats_checked, want[WORD_WIDTH-1:0], got[WORD_WIDTH-1:0],
                        want[RSP_DATA_WIDTH-1:WORD_WIDTH],
                        got[RSP_DATA_WIDTH-1:WORD_WIDTH]);
         end
      endfunction

      function int pending();
         return expected_blocks.size();
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset;
   logic [REQ_DATA_WIDTH-1:0]   req_tdata;
   logic                        req_tuser;
   logic                        req_tvalid;
   logic                        req_tready;
   logic [RSP_DATA_WIDTH-1:0]   rsp_tdata;
   logic                        rsp_tvalid;
   logic                        rsp_tready;
   logic                        csr_wr_en;
   logic [CSR_INDEX_WIDTH-1:0]  csr_index;
   logic [WORD_WIDTH-1:0]       csr_wdata;

   tea_scoreboard sb = new();
   int            burst_left = 0;
   bit            long_hold_done = 1'b0;

   tea_block_cipher_top #(.ROUND_COUNT(ROUNDS)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   task automatic write_csr(csr_index_type idx, logic [WORD_WIDTH-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_key(idx, value);
   endtask

   task automatic load_key(logic [WORD_WIDTH-1:0] k0, logic [WORD_WIDTH-1:0] k1,
                           logic [WORD_WIDTH-1:0] k2, logic [WORD_WIDTH-1:0] k3);
      write_csr(CSR_KEY_WORD_0, k0);
      write_csr(CSR_KEY_WORD_1, k1);
      write_csr(CSR_KEY_WORD_2, k2);
      write_csr(CSR_KEY_WORD_3, k3);
   endtask

   // drop valid and let the pipeline drain before touching the key
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_block(opcode_type op, logic [WORD_WIDTH-1:0] lo,
                             logic [WORD_WIDTH-1:0] hi);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(1, 60);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {hi, lo};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      sb.note_block(op, lo, hi);
   endtask

   function automatic logic [WORD_WIDTH-1:0] pick_word();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         2:       return 32'h8000_0000;
         default: return $urandom();
      endcase
   endfunction

   task automatic send_random(int count);
      int                        sent;
      logic [WORD_WIDTH-1:0]     lo;
      logic [WORD_WIDTH-1:0]     hi;
      logic [RSP_DATA_WIDTH-1:0] ct;
      opcode_type                op;
      sent = 0;
      while (sent < count) begin
         lo = pick_word();
         hi = pick_word();
         if ($urandom_range(0, 9) < 3) begin
            // round trip: the second block undoes the first
            op = opcode_type'($urandom_range(0, 1));
            ct = sb.cipher(op, lo, hi);
            send_block(op, lo, hi);
            send_block(op == OP_ENCRYPT ? OP_DECRYPT : OP_ENCRYPT,
                       ct[WORD_WIDTH-1:0], ct[RSP_DATA_WIDTH-1:WORD_WIDTH]);
            sent += 2;
         end else begin
            send_block(opcode_type'($urandom_range(0, 1)), lo, hi);
            sent++;
         end
      end
   endtask

   task automatic send_directed();
      send_block(OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
      send_block(OP_DECRYPT, 32'h0000_0000, 32'h0000_0000);
      send_block(OP_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_block(OP_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_block(OP_ENCRYPT, 32'h0000_0000, 32'hFFFF_FFFF);
      send_block(OP_DECRYPT, 32'hFFFF_FFFF, 32'h0000_0000);
      send_block(OP_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
      send_block(OP_DECRYPT, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
      send_block(OP_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF);
      send_block(OP_DECRYPT, 32'h89AB_CDEF, 32'h0123_4567);
   endtask

   // response side: check beats, then choose next tready
   initial begin
      int  hold_left;
      int  phase_count;
      bit  next_ready;
      hold_left   = 0;
      phase_count = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         phase_count++;
         if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else if (!long_hold_done && sb.beats_checked >= 700) begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD;
            next_ready     = 1'b0;
         end else begin
            case ((sb.beats_checked / 150) % 4)
               0:       next_ready = 1'b1;
               1:       next_ready = ($urandom_range(0, 3) != 0);
               2:       next_ready = (phase_count % 3 != 0);
               default: next_ready = ($urandom_range(0, 9) < 4);
            endcase
         end
         rsp_tready <= next_ready;
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      rsp_tready <= 1'b0;
      csr_wr_en  <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // key from reset: all zero
      send_directed();
      send_random(250);
      drain_pipeline();

      load_key('1, '1, '1, '1);
      send_directed();
      send_random(250);
      drain_pipeline();

      load_key($urandom(), $urandom(), $urandom(), $urandom());
      send_random(400);
      drain_pipeline();

      load_key(32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001);
      send_random(350);
      drain_pipeline();

      load_key($urandom(), $urandom(), $urandom(), $urandom());
      send_random(350);
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
